[rtl/tee_pkg.sv]
`default_nettype none

package tee_pkg;

  // Field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ADD_W     = 32;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned BYTES_W   = 48;
  localparam int unsigned SUMT_W    = 48;
  localparam int unsigned SUMB_W    = 56;
  localparam int unsigned SPEED_W   = 48;
  localparam int unsigned ETA_W     = 32;
  localparam int unsigned SMIN_W    = 16;
  localparam int unsigned STALL_W   = 20;
  localparam int unsigned REFR_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 48;

  // Item kinds carried on tuser
  localparam logic [FUNC_W-1:0] FUNC_RECORD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPORT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH = 2'd3;

  // Register reset values
  localparam logic [BYTES_W-1:0] TOTAL_RST = 48'd0;
  localparam logic [SMIN_W-1:0]  SMIN_RST  = 16'd150;
  localparam logic [STALL_W-1:0] STALL_RST = 20'd5000;
  localparam logic [REFR_W-1:0]  REFR_RST  = 20'd1000;

  // Serial multiplier: a is scanned MSB first, one bit per step
  localparam int unsigned MUL_AW = 40;
  localparam int unsigned MUL_BW = 56;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_SW = $clog2(MUL_AW + 1);

  // Serial restoring divider: one quotient bit per step
  localparam int unsigned DIV_NW = 88;
  localparam int unsigned DIV_DW = 58;
  localparam int unsigned DIV_QW = 48;
  localparam int unsigned DIV_SW = $clog2(DIV_NW + 1);

  // Milliseconds per second, placed in the top bits of the multiplier operand
  localparam int unsigned        MS_W       = 10;
  localparam logic [MS_W-1:0]    MS_PER_S   = 10'd1000;
  localparam logic [MUL_AW-1:0]  MS_ALIGNED = {MS_PER_S, {(MUL_AW - MS_W){1'b0}}};
  localparam int unsigned        SPD_NUM_W  = MUL_BW + MS_W;

  localparam logic [TIME_W-1:0] STALL_AGE      = 40'd1000;
  localparam logic [TIME_W-1:0] ETA_MIN_TIME   = 40'd3000;
  localparam logic [SUMT_W-1:0] SPEED_MIN_TIME = 48'd999;
  localparam logic [ETA_W-1:0]  ETA_LIMIT      = 32'hFFFF_FFFE;

  typedef struct packed {
    logic              start;
    logic [MUL_SW-1:0] steps;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic over;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/tee_ram.sv]
`default_nettype none

module tee_ram #(
  parameter  int unsigned WIDTH = 88,
  parameter  int unsigned DEPTH = 20,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tee_mul.sv]
`default_nettype none

module tee_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tee_pkg::mul_req_t           req_i,
  input  logic [tee_pkg::MUL_AW-1:0]  a_i,
  input  logic [tee_pkg::MUL_BW-1:0]  b_i,
  output logic                        done_o,
  output logic [tee_pkg::MUL_PW-1:0]  p_o
);

  import tee_pkg::*;

  logic [MUL_AW-1:0] a_q, a_d;
  logic [MUL_BW-1:0] b_q, b_d;
  logic [MUL_PW-1:0] acc_q, acc_d;
  logic [MUL_SW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;

  // Shift-add: double the partial product, add b when the next bit of a is set
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      acc_d  = {acc_q[MUL_PW-2:0], 1'b0} + (a_q[MUL_AW-1] ? MUL_PW'(b_q) : '0);
      a_d    = {a_q[MUL_AW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MUL_SW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

[rtl/tee_div.sv]
`default_nettype none

module tee_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tee_pkg::div_req_t           req_i,
  input  logic [tee_pkg::DIV_NW-1:0]  num_i,
  input  logic [tee_pkg::DIV_DW-1:0]  den_i,
  output tee_pkg::div_rsp_t           rsp_o,
  output logic [tee_pkg::DIV_QW-1:0]  quo_o,
  output logic [tee_pkg::DIV_DW-1:0]  rem_o
);

  import tee_pkg::*;

  logic [DIV_NW-1:0] num_q, num_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_QW-1:0] quo_q, quo_d;
  logic              over_q, over_d;
  logic [DIV_SW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // Bring in the next numerator bit and try the subtraction
  assign trial = {rem_q, num_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    over_d = over_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      over_d = 1'b0;
      cnt_d  = req_i.steps;
    end else if (cnt_q != '0) begin
      num_d  = {num_q[DIV_NW-2:0], 1'b0};
      rem_d  = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      // quotient bits pushed past the top make the result overflow
      quo_d  = {quo_q[DIV_QW-2:0], fits};
      over_d = over_q | quo_q[DIV_QW-1];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_SW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    over_q <= over_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.over = over_q;
  assign quo_o      = quo_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

[rtl/throughput_eta_estimator.sv]
`default_nettype none

// Channel  Dir  Handshake                   Payload, lowest bits first
// s_axis   in   s_axis_tvalid/tready        tdata: bytes_written[31:0], time_ms[71:32],
//                                           done_count[119:72]; tuser: func[1:0]
// m_axis   out  m_axis_tvalid/tready        tdata: rate_bps[47:0], eta_seconds[79:48]
// cfg      in   cfg_we_i (no handshake)     idx 0 xfer_size, 1 sample_min_ms,
//                                           2 stall_time_ms, 3 eta_refresh_ms
//
// A record item passes REC_A, and REC_B when it stores a sample; a restart or unused code ends in IDLE.
// A report item checks the speed, and when it is known runs the bit-serial multiplier (10 steps) and
// divider (66); a fresh ETA runs the multiplier twice (10, 40 steps) and the divider (88).
// Reset loads the register defaults and empties the ring through per-entry valid flags.
// A finished report waits in the output register while the next item is taken; a
// second report holds in its last state until that register is free.

module throughput_eta_estimator #(
  parameter int unsigned HISTORY_DEPTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [119:0]                   s_axis_tdata,  // bytes_written, time_ms, done_count
  input  logic [tee_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [79:0]                    m_axis_tdata,  // rate_bps, eta_seconds
  input  logic                           cfg_we_i,
  input  logic [tee_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tee_pkg::CFG_W-1:0]      cfg_data_i
);

  import tee_pkg::*;

  localparam int unsigned PW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned RING_W = TIME_W + BYTES_W;
  localparam int unsigned OUT_W  = SPEED_W + ETA_W;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_REC_A   = 4'd1;
  localparam logic [3:0] ST_REC_B   = 4'd2;
  localparam logic [3:0] ST_SPD_CHK = 4'd3;
  localparam logic [3:0] ST_SPD_MUL = 4'd4;
  localparam logic [3:0] ST_SPD_DIV = 4'd5;
  localparam logic [3:0] ST_ETA_CHK = 4'd6;
  localparam logic [3:0] ST_ETA_DEN = 4'd7;
  localparam logic [3:0] ST_ETA_MUL = 4'd8;
  localparam logic [3:0] ST_ETA_DIV = 4'd9;
  localparam logic [3:0] ST_OUT     = 4'd10;

  // Input fields
  logic [ADD_W-1:0]   in_add;
  logic [TIME_W-1:0]  in_now;
  logic [BYTES_W-1:0] in_done;
  logic               in_acc;

  assign in_add  = s_axis_tdata[ADD_W-1:0];
  assign in_now  = s_axis_tdata[ADD_W+TIME_W-1:ADD_W];
  assign in_done = s_axis_tdata[ADD_W+TIME_W+BYTES_W-1:ADD_W+TIME_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  logic [BYTES_W-1:0] total_q;
  logic [SMIN_W-1:0]  smin_q;
  logic [STALL_W-1:0] stall_q;
  logic [REFR_W-1:0]  refr_q;

  // Control and estimator state
  logic [3:0]               state_q, state_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic [HISTORY_DEPTH-1:0] vld_q, vld_d;
  logic [SUMT_W-1:0]        sum_t_q, sum_t_d;
  logic [SUMB_W-1:0]        sum_b_q, sum_b_d;
  logic [TIME_W-1:0]        wstart_q, wstart_d;
  logic [BYTES_W-1:0]       wbytes_q, wbytes_d;
  logic                     stall_flag_q, stall_flag_d;
  logic [ETA_W-1:0]         ceta_q, ceta_d;
  logic [TIME_W-1:0]        ctime_q, ctime_d;
  logic                     rd_vld_q;
  logic                     m_valid_q, m_valid_d;

  // Item and result payload
  logic [ADD_W-1:0]   add_q, add_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [BYTES_W-1:0] done_q, done_d;
  logic [TIME_W-1:0]  age_q, age_d;
  logic [DIV_DW-1:0]  den_q, den_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [ETA_W-1:0]   eta_q, eta_d;
  logic [OUT_W-1:0]   m_data_q, m_data_d;

  // Ring memory
  logic              ram_we;
  logic [RING_W-1:0] ram_wdata;
  logic [RING_W-1:0] ram_rdata;
  logic [TIME_W-1:0] old_t;
  logic [BYTES_W-1:0] old_b;

  // Arithmetic units
  mul_req_t           mul_req;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic               mul_done;
  logic [MUL_PW-1:0]  mul_p;
  div_req_t           div_req;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  div_rsp_t           div_rsp;
  logic [DIV_QW-1:0]  div_quo;
  logic [DIV_DW-1:0]  div_rem;

  // Helpers
  logic [BYTES_W:0]   wsum;
  logic [BYTES_W-1:0] wb_sat;
  logic [SUMT_W:0]    span;
  logic [TIME_W-1:0]  cache_age;
  logic               round_up;
  logic [ETA_W-1:0]   eta_new;

  assign wsum      = {1'b0, wbytes_q} + (BYTES_W + 1)'(add_q);
  assign wb_sat    = wsum[BYTES_W] ? '1 : wsum[BYTES_W-1:0];
  assign span      = {1'b0, sum_t_q} + (SUMT_W + 1)'(age_q);
  assign cache_age = now_q - ctime_q;
  assign round_up  = ({div_rem, 1'b0} >= {1'b0, den_q});
  assign eta_new   = div_quo[ETA_W-1:0] + ETA_W'(round_up);
  assign old_t     = rd_vld_q ? ram_rdata[TIME_W-1:0] : '0;
  assign old_b     = rd_vld_q ? ram_rdata[RING_W-1:TIME_W] : '0;
  assign ram_wdata = {wbytes_q, age_q};

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    vld_d        = vld_q;
    sum_t_d      = sum_t_q;
    sum_b_d      = sum_b_q;
    wstart_d     = wstart_q;
    wbytes_d     = wbytes_q;
    stall_flag_d = stall_flag_q;
    ceta_d       = ceta_q;
    ctime_d      = ctime_q;
    m_valid_d    = m_valid_q & ~m_axis_tready;
    add_d        = add_q;
    now_d        = now_q;
    done_d       = done_q;
    age_d        = age_q;
    den_d        = den_q;
    speed_d      = speed_q;
    eta_d        = eta_q;
    m_data_d     = m_data_q;
    ram_we       = 1'b0;
    mul_req      = '0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    div_num      = '0;
    div_den      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          add_d  = in_add;
          now_d  = in_now;
          done_d = in_done;
          age_d  = in_now - wstart_q;
          case (s_axis_tuser)
            FUNC_RECORD: state_d = ST_REC_A;
            FUNC_REPORT: state_d = ST_SPD_CHK;
            FUNC_RESTART: begin
              // clear all estimator state, keep the registers
              pos_d        = '0;
              vld_d        = '0;
              sum_t_d      = '0;
              sum_b_d      = '0;
              wstart_d     = '0;
              wbytes_d     = '0;
              stall_flag_d = 1'b0;
              ceta_d       = '0;
              ctime_d      = '0;
            end
            default: ;
          endcase
        end
      end

      // Accumulate bytes, then drop, stall or retire the oldest ring entry
      ST_REC_A: begin
        wbytes_d = wb_sat;
        state_d  = ST_IDLE;
        if (age_q >= TIME_W'(smin_q)) begin
          if (add_q == '0) begin
            if (age_q >= TIME_W'(stall_q)) begin
              stall_flag_d = 1'b1;
              vld_d        = '0;
              pos_d        = '0;
              sum_t_d      = '0;
              sum_b_d      = '0;
              wbytes_d     = '0;
            end
          end else begin
            age_d        = stall_flag_q ? STALL_AGE : age_q;
            stall_flag_d = 1'b0;
            sum_t_d      = sum_t_q - SUMT_W'(old_t);
            sum_b_d      = sum_b_q - SUMB_W'(old_b);
            state_d      = ST_REC_B;
          end
        end
      end

      // Store the new sample and open a fresh window
      ST_REC_B: begin
        ram_we       = 1'b1;
        vld_d[pos_q] = 1'b1;
        sum_t_d      = sum_t_q + SUMT_W'(age_q);
        sum_b_d      = sum_b_q + SUMB_W'(wbytes_q);
        wstart_d     = now_q;
        wbytes_d     = '0;
        pos_d        = (pos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        state_d      = ST_IDLE;
      end

      ST_SPD_CHK: begin
        if (sum_t_q <= SPEED_MIN_TIME || sum_b_q == '0) begin
          speed_d = '0;
          state_d = ST_ETA_CHK;
        end else begin
          mul_req.start = 1'b1;
          mul_req.steps = MUL_SW'(MS_W);
          mul_a         = MS_ALIGNED;
          mul_b         = sum_b_q + SUMB_W'(wbytes_q);
          state_d       = ST_SPD_MUL;
        end
      end

      ST_SPD_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.steps = DIV_SW'(SPD_NUM_W);
          div_num       = {mul_p[SPD_NUM_W-1:0], {(DIV_NW - SPD_NUM_W){1'b0}}};
          div_den       = DIV_DW'(span);
          state_d       = ST_SPD_DIV;
        end
      end

      ST_SPD_DIV: begin
        if (div_rsp.done) begin
          speed_d = div_rsp.over ? '1 : div_quo[SPEED_W-1:0];
          state_d = ST_ETA_CHK;
        end
      end

      // Unknown, cached or needs a fresh quotient
      ST_ETA_CHK: begin
        state_d = ST_OUT;
        if (total_q == '0 || done_q == '0 || now_q < ETA_MIN_TIME) begin
          eta_d = '1;
        end else if (ceta_q != '0 && total_q != done_q &&
                     cache_age < TIME_W'(refr_q)) begin
          eta_d = ceta_q;
        end else if (done_q > total_q) begin
          eta_d = '1;
        end else begin
          mul_req.start = 1'b1;
          mul_req.steps = MUL_SW'(MS_W);
          mul_a         = MS_ALIGNED;
          mul_b         = MUL_BW'(done_q);
          state_d       = ST_ETA_DEN;
        end
      end

      ST_ETA_DEN: begin
        if (mul_done) begin
          den_d         = mul_p[DIV_DW-1:0];
          mul_req.start = 1'b1;
          mul_req.steps = MUL_SW'(MUL_AW);
          mul_a         = now_q;
          mul_b         = MUL_BW'(total_q - done_q);
          state_d       = ST_ETA_MUL;
        end
      end

      ST_ETA_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.steps = DIV_SW'(DIV_NW);
          div_num       = mul_p[DIV_NW-1:0];
          div_den       = den_q;
          state_d       = ST_ETA_DIV;
        end
      end

      // Round half up from the remainder, refresh the cache
      ST_ETA_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.over || div_quo[DIV_QW-1:ETA_W] != '0 ||
              div_quo[ETA_W-1:0] >= ETA_LIMIT) begin
            eta_d = '1;
          end else begin
            eta_d   = eta_new;
            ceta_d  = eta_new;
            ctime_d = now_q;
          end
          state_d = ST_OUT;
        end
      end

      // Hold until the output register is free
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {eta_q, speed_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      smin_q  <= SMIN_RST;
      stall_q <= STALL_RST;
      refr_q  <= REFR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL:   total_q <= cfg_data_i[BYTES_W-1:0];
        REG_SMIN:    smin_q  <= cfg_data_i[SMIN_W-1:0];
        REG_STALL:   stall_q <= cfg_data_i[STALL_W-1:0];
        REG_REFRESH: refr_q  <= cfg_data_i[REFR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      vld_q        <= '0;
      sum_t_q      <= '0;
      sum_b_q      <= '0;
      wstart_q     <= '0;
      wbytes_q     <= '0;
      stall_flag_q <= 1'b0;
      ceta_q       <= '0;
      ctime_q      <= '0;
      rd_vld_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      vld_q        <= vld_d;
      sum_t_q      <= sum_t_d;
      sum_b_q      <= sum_b_d;
      wstart_q     <= wstart_d;
      wbytes_q     <= wbytes_d;
      stall_flag_q <= stall_flag_d;
      ceta_q       <= ceta_d;
      ctime_q      <= ctime_d;
      rd_vld_q     <= vld_q[pos_q];
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q    <= add_d;
    now_q    <= now_d;
    done_q   <= done_d;
    age_q    <= age_d;
    den_q    <= den_d;
    speed_q  <= speed_d;
    eta_q    <= eta_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  tee_ram #(
    .WIDTH (RING_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  tee_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  tee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

endmodule

`default_nettype wire
